// ===== hdl/hfs_pkg.sv =====
`default_nettype none

package hfs_pkg;

   // scoreboard depth, one entry per architectural register
   localparam int REG_COUNT = 32;

   // age bookkeeping
   localparam int AGE_W = 3;
   localparam logic [AGE_W-1:0] AGE_INSERT  = AGE_W'(2);
   localparam logic [AGE_W-1:0] AGE_NEAR    = AGE_W'(3);
   localparam logic [AGE_W-1:0] AGE_REGFILE = AGE_W'(5);
   localparam logic [AGE_W-1:0] AGE_DROP    = AGE_W'(6);

   // operand source codes for sel_a / sel_b
   localparam logic [1:0] SEL_REGFILE = 2'd0;
   localparam logic [1:0] SEL_EXDM    = 2'd1;
   localparam logic [1:0] SEL_DMWB    = 2'd2;

   // store data source codes
   localparam logic [1:0] STORE_REGFILE  = 2'd0;
   localparam logic [1:0] STORE_DMWB_MEM = 2'd1;
   localparam logic [1:0] STORE_DMWB_EX  = 2'd2;

   // one decoded instruction
   typedef struct packed {
      logic [4:0] src_a_reg;
      logic       src_a_used;
      logic [4:0] src_b_reg;
      logic       src_b_used;
      logic [4:0] store_reg;
      logic       store_used;
      logic [4:0] dest_reg;
      logic       dest_writes;
      logic       dest_is_load;
   } req_type;

   // forwarding decision
   typedef struct packed {
      logic       stall_res;
      logic [1:0] sel_a;
      logic [1:0] sel_b;
      logic [1:0] sel_store;
   } rsp_type;

   // one scoreboard entry as seen by a lookup
   typedef struct packed {
      logic             valid;
      logic [AGE_W-1:0] age;
      logic             is_load;
   } entry_type;

   // lookup results for the three operands
   typedef struct packed {
      entry_type a;
      entry_type b;
      entry_type st;
   } lookup_type;

endpackage

`default_nettype wire

// ===== hdl/hfs_scoreboard.sv =====
`default_nettype none

module hfs_scoreboard
   import hfs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire req_type    req,
   input  wire logic       mark,
   output lookup_type      lookup
);

   logic [REG_COUNT-1:0]            valid_ff;
   logic [REG_COUNT-1:0]            valid_in;
   logic [REG_COUNT-1:0][AGE_W-1:0] age_ff;
   logic [REG_COUNT-1:0][AGE_W-1:0] age_in;
   logic [REG_COUNT-1:0]            load_ff;
   logic [REG_COUNT-1:0]            load_in;
   logic [REG_COUNT-1:0]            hit_a;
   logic [REG_COUNT-1:0]            hit_b;
   logic [REG_COUNT-1:0]            hit_st;

   for (genvar i = 0; i < REG_COUNT; i++) begin : g_entry
      logic [AGE_W-1:0] age_next;

      // per-entry tag compare; registers past the table never hit
      assign hit_a[i]  = valid_ff[i] && (int'(req.src_a_reg) == i);
      assign hit_b[i]  = valid_ff[i] && (int'(req.src_b_reg) == i);
      assign hit_st[i] = valid_ff[i] && (int'(req.store_reg) == i);

      // insert at age 2 and age in the same pass, or just age, dropping the entry once it reaches age 6
      always_comb begin
         age_next    = age_ff[i] + AGE_W'(1);
         valid_in[i] = valid_ff[i];
         age_in[i]   = age_ff[i];
         load_in[i]  = load_ff[i];
         if (mark && (int'(req.dest_reg) == i)) begin
            valid_in[i] = 1'b1;
            age_in[i]   = AGE_INSERT + AGE_W'(1);
            load_in[i]  = req.dest_is_load;
         end else if (valid_ff[i]) begin
            if (age_next >= AGE_DROP) begin
               valid_in[i] = 1'b0;
            end else begin
               age_in[i] = age_next;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_in[i];
         end
      end

      // age and load flag are only read while valid
      always_ff @(posedge clock) begin
         if (advance) begin
            age_ff[i]  <= age_in[i];
            load_ff[i] <= load_in[i];
         end
      end
   end

   // one-hot hits: take the matching entry
   always_comb begin
      lookup = '0;
      for (int i = 0; i < REG_COUNT; i++) begin
         if (hit_a[i]) begin
            lookup.a = '{valid: 1'b1, age: age_ff[i], is_load: load_ff[i]};
         end
         if (hit_b[i]) begin
            lookup.b = '{valid: 1'b1, age: age_ff[i], is_load: load_ff[i]};
         end
         if (hit_st[i]) begin
            lookup.st = '{valid: 1'b1, age: age_ff[i], is_load: load_ff[i]};
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hfs_check.sv =====
`default_nettype none

module hfs_check
   import hfs_pkg::*;
(
   input  wire req_type    req,
   input  wire lookup_type lookup,
   output rsp_type         rsp
);

   logic       live_a;
   logic       live_b;
   logic       live_st;
   logic       stall_a;
   logic       stall_b;
   logic [1:0] sel_a;
   logic [1:0] sel_b;
   logic [1:0] sel_st;

   // a pending write that has not yet reached the register file
   assign live_a  = req.src_a_used && lookup.a.valid && (lookup.a.age < AGE_REGFILE);
   assign live_b  = req.src_b_used && lookup.b.valid && (lookup.b.age < AGE_REGFILE);
   assign live_st = req.store_used && lookup.st.valid && (lookup.st.age < AGE_REGFILE);

   // load-use: load result not out of memory yet
   assign stall_a = live_a && lookup.a.is_load && (lookup.a.age <= AGE_NEAR);
   assign stall_b = live_b && lookup.b.is_load && (lookup.b.age <= AGE_NEAR);

   always_comb begin
      sel_a = SEL_REGFILE;
      if (live_a) begin
         sel_a = (lookup.a.age <= AGE_NEAR) ? SEL_EXDM : SEL_DMWB;
      end
      sel_b = SEL_REGFILE;
      if (live_b) begin
         sel_b = (lookup.b.age <= AGE_NEAR) ? SEL_EXDM : SEL_DMWB;
      end
      sel_st = STORE_REGFILE;
      if (live_st) begin
         sel_st = (lookup.st.age <= AGE_NEAR) ? STORE_DMWB_MEM : STORE_DMWB_EX;
      end
   end

   // a stall squashes every select
   always_comb begin
      rsp.stall_res = stall_a || stall_b;
      rsp.sel_a     = rsp.stall_res ? SEL_REGFILE : sel_a;
      rsp.sel_b     = rsp.stall_res ? SEL_REGFILE : sel_b;
      rsp.sel_store = rsp.stall_res ? STORE_REGFILE : sel_st;
   end

endmodule

`default_nettype wire

// ===== hdl/pipeline_hazard_forwarding_scoreboard.sv =====
`default_nettype none

// Forwarding and load-use hazard unit for a five-stage pipeline. Drive one
// decoded instruction per pipeline cycle with start; a request can be issued
// every clock once busy is low (busy is a registered copy of reset, so it is
// high while reset is applied and clears in the cycle after it is released).
// The answer (stall flag and the three operand selects) appears on rsp_data
// with rsp_strobe after the request passes through the request register,
// then through the scoreboard lookup into the response register. The
// response cannot be held off. The scoreboard ages per request, not per
// clock, so idle cycles do not retire pending writes.
module pipeline_hazard_forwarding_scoreboard
   import hfs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   logic       busy_ff;
   logic       stage_valid_ff;
   req_type    stage_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   lookup_type lookup;
   logic       mark;

   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         stage_ff <= req_data;
      end
   end

   hfs_scoreboard u_scoreboard (
      .clock   (clock),
      .reset   (reset),
      .advance (stage_valid_ff),
      .req     (stage_ff),
      .mark    (mark),
      .lookup  (lookup)
   );

   hfs_check u_check (
      .req    (stage_ff),
      .lookup (lookup),
      .rsp    (rsp_in)
   );

   // record the destination only when the instruction moves on
   assign mark = stage_ff.dest_writes && !rsp_in.stall_res;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   // every accepted request is answered through the request and response registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("request not answered after two cycles");

   // no response without a request in the stage
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(stage_valid_ff))
      else $error("response without request");

   // a stall carries no forwarding select
   a_stall_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.stall_res) |->
         (rsp_data.sel_a == SEL_REGFILE && rsp_data.sel_b == SEL_REGFILE &&
          rsp_data.sel_store == STORE_REGFILE))
      else $error("stall with nonzero select");

   // a stalled instruction never marks its destination
   a_no_mark_on_stall: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_in.stall_res) |-> !mark)
      else $error("destination marked on stall");
`endif

endmodule

`default_nettype wire
